@@ rtl/tfw_pkg.sv @@
// ----------------------------------------------------------------------------
// tfw_pkg
// Shared widths, constants, word types and width helpers for the tangent-frame
// to world transform.
// ----------------------------------------------------------------------------
package tfw_pkg;

    localparam int DATA_W        = 16;
    localparam int WORLD_W       = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int FRAME_BITS    = 30;

    localparam int SQ_W     = 31;   // one squared normal component
    localparam int L2_W     = 32;   // sum of squared normal components
    localparam int PR_W     = 32;   // cross product of two normal components
    localparam int UPM_W    = 52;   // up-axis test products
    localparam int LANE_MW  = 32;   // lane numerator magnitude
    localparam int LANE_SW  = 64;   // lane squared denominator
    localparam int LANE_CW  = 34;   // signed lane numerator before abs
    localparam int FRAME_LN = 8;    // z0..z2, two x terms, y0..y2
    localparam int WORLD_LN = 3;
    localparam int AX_W     = 32;   // signed frame component
    localparam int P_W      = 48;   // local times frame component
    localparam int W_W      = 50;   // rotated component
    localparam int WMAG_W   = 49;
    localparam int WN_W     = 31;   // rotated magnitude after block shift
    localparam int SH_W     = 5;
    localparam int SS_W     = 64;

    localparam logic [19:0] UP_NUM = 20'd1000000;
    localparam logic [19:0] UP_DEN = 20'd998001;

    typedef struct packed {
        logic signed [DATA_W-1:0] local_x;
        logic signed [DATA_W-1:0] local_y;
        logic signed [DATA_W-1:0] local_z;
        logic signed [DATA_W-1:0] normal_x;
        logic signed [DATA_W-1:0] normal_y;
        logic signed [DATA_W-1:0] normal_z;
    } t_in_word;

    typedef struct packed {
        logic signed [WORLD_W-1:0] world_x;
        logic signed [WORLD_W-1:0] world_y;
        logic signed [WORLD_W-1:0] world_z;
        logic                      invalid;
    } t_out_word;

    // residual width of the rounding search
    function automatic int e_width(input int mw, input int sw, input int f);
        int a;
        int b;
        a = 2 * mw + 2 * f + 2;
        b = sw + 2 * f + 4;
        return ((a > b) ? a : b) + 4;
    endfunction

    // width of (2k-1)*S
    function automatic int q_width(input int sw, input int f);
        return sw + f + 4;
    endfunction

endpackage

@@ rtl/tfw_if.sv @@
// ----------------------------------------------------------------------------
// tfw_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface tfw_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tfw_cell.sv @@
// ----------------------------------------------------------------------------
// tfw_cell
// One bit step of the rounded ratio search, for several lanes: try setting
// bit BIT of k, keep it when (2k-1)^2*S still fits under the target.
// ----------------------------------------------------------------------------
module tfw_cell #(
    parameter int LANES = 1,
    parameter int MW    = 32,
    parameter int SW    = 64,
    parameter int F     = 30,
    parameter int BIT   = 0,
    parameter int XW    = 1
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_vld,
    input  logic [XW-1:0]                                 i_x,
    input  logic signed [tfw_pkg::e_width(MW, SW, F)-1:0] i_e    [LANES],
    input  logic signed [tfw_pkg::q_width(SW, F)-1:0]     i_q    [LANES],
    input  logic [SW-1:0]                                 i_s    [LANES],
    input  logic [F:0]                                    i_k    [LANES],
    input  logic                                          i_neg  [LANES],
    input  logic                                          i_zero [LANES],
    output logic                                          o_vld,
    output logic [XW-1:0]                                 o_x,
    output logic signed [tfw_pkg::e_width(MW, SW, F)-1:0] o_e    [LANES],
    output logic signed [tfw_pkg::q_width(SW, F)-1:0]     o_q    [LANES],
    output logic [SW-1:0]                                 o_s    [LANES],
    output logic [F:0]                                    o_k    [LANES],
    output logic                                          o_neg  [LANES],
    output logic                                          o_zero [LANES]
);
    import tfw_pkg::*;

    localparam int EW = e_width(MW, SW, F);
    localparam int QW = q_width(SW, F);

    logic signed [EW-1:0] w_cand [LANES];
    logic signed [EW-1:0] n_e    [LANES];
    logic signed [QW-1:0] n_q    [LANES];
    logic [F:0]           n_k    [LANES];

    logic                 r_vld;
    logic [XW-1:0]        r_x;
    logic signed [EW-1:0] r_e    [LANES];
    logic signed [QW-1:0] r_q    [LANES];
    logic [SW-1:0]        r_s    [LANES];
    logic [F:0]           r_k    [LANES];
    logic                 r_neg  [LANES];
    logic                 r_zero [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_cand[l] = i_e[l] - (EW'(i_q[l]) <<< (BIT + 2))
                        - (EW'(i_s[l]) << (2 * BIT + 2));
            if (!w_cand[l][EW-1]) begin
                n_e[l] = w_cand[l];
                n_q[l] = i_q[l] + (QW'(i_s[l]) << (BIT + 1));
                n_k[l] = i_k[l] | ((F + 1)'(1) << BIT);
            end else begin
                n_e[l] = i_e[l];
                n_q[l] = i_q[l];
                n_k[l] = i_k[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= i_x;
            for (int l = 0; l < LANES; l++) begin
                r_e[l]    <= n_e[l];
                r_q[l]    <= n_q[l];
                r_s[l]    <= i_s[l];
                r_k[l]    <= n_k[l];
                r_neg[l]  <= i_neg[l];
                r_zero[l] <= i_zero[l];
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_e    = r_e;
    assign o_q    = r_q;
    assign o_s    = r_s;
    assign o_k    = r_k;
    assign o_neg  = r_neg;
    assign o_zero = r_zero;

endmodule

@@ rtl/tfw_chain.sv @@
// ----------------------------------------------------------------------------
// tfw_chain
// Row of F+1 search cells with a two-stage setup: returns per lane
// k = round(m * 2^F / sqrt(S)), or zero where m or S is zero.
// ----------------------------------------------------------------------------
module tfw_chain #(
    parameter int LANES = 1,
    parameter int MW    = 32,
    parameter int SW    = 64,
    parameter int F     = 30,
    parameter int XW    = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [XW-1:0] i_x,
    input  logic [MW-1:0] i_m   [LANES],
    input  logic          i_neg [LANES],
    input  logic [SW-1:0] i_s   [LANES],
    output logic          o_vld,
    output logic [XW-1:0] o_x,
    output logic [F:0]    o_k   [LANES],
    output logic          o_neg [LANES]
);
    import tfw_pkg::*;

    localparam int EW = e_width(MW, SW, F);
    localparam int QW = q_width(SW, F);

    logic                  r_a_vld;
    logic [XW-1:0]         r_a_x;
    logic [2*MW-1:0]       r_a_sq   [LANES];
    logic [SW-1:0]         r_a_s    [LANES];
    logic                  r_a_neg  [LANES];
    logic                  r_a_zero [LANES];

    logic                  c_vld  [F+2];
    logic [XW-1:0]         c_x    [F+2];
    logic signed [EW-1:0]  c_e    [F+2][LANES];
    logic signed [QW-1:0]  c_q    [F+2][LANES];
    logic [SW-1:0]         c_s    [F+2][LANES];
    logic [F:0]            c_k    [F+2][LANES];
    logic                  c_neg  [F+2][LANES];
    logic                  c_zero [F+2][LANES];

    logic                  r_b_vld;
    logic [XW-1:0]         r_b_x;
    logic signed [EW-1:0]  r_b_e    [LANES];
    logic signed [QW-1:0]  r_b_q    [LANES];
    logic [SW-1:0]         r_b_s    [LANES];
    logic                  r_b_neg  [LANES];
    logic                  r_b_zero [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
        end
    end

    // square the numerator, then seed residual = m^2*2^(2F+2) - S, Q = -S
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x <= i_x;
            r_b_x <= r_a_x;
            for (int l = 0; l < LANES; l++) begin
                r_a_sq[l]   <= (2 * MW)'(i_m[l]) * (2 * MW)'(i_m[l]);
                r_a_s[l]    <= i_s[l];
                r_a_neg[l]  <= i_neg[l];
                r_a_zero[l] <= (i_m[l] == '0) || (i_s[l] == '0);
                r_b_e[l]    <= (EW'(r_a_sq[l]) << (2 * F + 2)) - EW'(r_a_s[l]);
                r_b_q[l]    <= -QW'(r_a_s[l]);
                r_b_s[l]    <= r_a_s[l];
                r_b_neg[l]  <= r_a_neg[l];
                r_b_zero[l] <= r_a_zero[l];
            end
        end
    end

    always_comb begin
        c_vld[0] = r_b_vld;
        c_x[0]   = r_b_x;
        for (int l = 0; l < LANES; l++) begin
            c_e[0][l]    = r_b_e[l];
            c_q[0][l]    = r_b_q[l];
            c_s[0][l]    = r_b_s[l];
            c_k[0][l]    = '0;
            c_neg[0][l]  = r_b_neg[l];
            c_zero[0][l] = r_b_zero[l];
        end
    end

    for (genvar j = 0; j <= F; j++) begin : g_cell
        tfw_cell #(
            .LANES (LANES),
            .MW    (MW),
            .SW    (SW),
            .F     (F),
            .BIT   (F - j),
            .XW    (XW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (c_vld[j]),
            .i_x    (c_x[j]),
            .i_e    (c_e[j]),
            .i_q    (c_q[j]),
            .i_s    (c_s[j]),
            .i_k    (c_k[j]),
            .i_neg  (c_neg[j]),
            .i_zero (c_zero[j]),
            .o_vld  (c_vld[j+1]),
            .o_x    (c_x[j+1]),
            .o_e    (c_e[j+1]),
            .o_q    (c_q[j+1]),
            .o_s    (c_s[j+1]),
            .o_k    (c_k[j+1]),
            .o_neg  (c_neg[j+1]),
            .o_zero (c_zero[j+1])
        );
    end

    assign o_vld = c_vld[F+1];
    assign o_x   = c_x[F+1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_k[l]   = c_zero[F+1][l] ? '0 : c_k[F+1][l];
            o_neg[l] = c_neg[F+1][l];
        end
    end

endmodule

@@ rtl/tangent_frame_local_to_world.sv @@
// ----------------------------------------------------------------------------
// tangent_frame_local_to_world
// Builds an orthonormal frame around a surface normal and rotates a local
// direction into world space, returning a unit Q1.FRAC_BITS vector.
//
//   channel | dir | words                      | handshake
//   i_in    | in  | local xyz, normal xyz      | valid/ready
//   o_out   | out | world xyz, invalid         | valid/ready
//
// One word enters per cycle unless the output register stalls; the pipeline
// holds two rows of search cells (31 frame bits, FRAC_BITS+1 world bits).
// All stages advance together; they hold only while the output register is
// full and not taken, and i_in.ready follows that same enable.
// Reset clears the valid bits of every stage; no clearing pass.
// ----------------------------------------------------------------------------
module tangent_frame_local_to_world #(
    parameter int FRAC_BITS = tfw_pkg::FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tfw_if.sink   i_in,
    tfw_if.source o_out
);
    import tfw_pkg::*;

    localparam int XW1 = 3 * DATA_W + 2;

    logic w_en;

    // normal front end
    logic                     r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    logic signed [DATA_W-1:0] r1_l [3], r2_l [3], r3_l [3], r4_l [3], r5_l [3];
    logic signed [DATA_W-1:0] r1_n [3], r2_n [3], r3_n [3], r4_n [3];
    logic [SQ_W-1:0]          r1_sq [3];
    logic [SQ_W-1:0]          r2_ny2;
    logic signed [PR_W-1:0]   r1_nxy, r1_nyz, r1_nxz;
    logic signed [PR_W-1:0]   r2_nxy, r2_nyz, r2_nxz;
    logic signed [PR_W-1:0]   r3_nxy, r3_nyz, r3_nxz;
    logic signed [PR_W-1:0]   r4_nxy, r4_nyz, r4_nxz;
    logic [L2_W-1:0]          r2_l2, r2_h2, r2_g2;
    logic [L2_W-1:0]          r3_l2, r3_h2, r3_g2;
    logic [UPM_W-1:0]         r3_a, r3_b;
    logic [L2_W-1:0]          r4_l2, r4_q2;
    logic                     r4_upy, r4_inv;
    logic [L2_W-1:0]          r5_l2, r5_q2;
    logic [SS_W-1:0]          r5_s2;
    logic                     r5_upy, r5_inv;
    logic [LANE_MW-1:0]       r5_m   [FRAME_LN];
    logic                     r5_neg [FRAME_LN];
    logic signed [LANE_CW-1:0] w_c   [FRAME_LN];
    logic signed [LANE_CW-1:0] w_q2s;

    // frame chain
    logic [XW1-1:0]           w_c1_xin;
    logic [LANE_SW-1:0]       w_c1_s [FRAME_LN];
    logic                     c1_vld;
    logic [XW1-1:0]           c1_x;
    logic [FRAME_BITS:0]      c1_k   [FRAME_LN];
    logic                     c1_neg [FRAME_LN];
    logic signed [AX_W-1:0]   w_v    [FRAME_LN];
    logic signed [AX_W-1:0]   w_bas  [3][3];   // [basis][component]
    logic signed [DATA_W-1:0] w_c1_l [3];

    // rotation and block shift
    logic                     r6_vld, r7_vld, r8_vld, r9_vld, r10_vld;
    logic                     r11_vld, r12_vld, r13_vld;
    logic                     r6_inv, r7_inv, r8_inv, r9_inv, r10_inv;
    logic                     r11_inv, r12_inv, r13_inv;
    logic signed [P_W-1:0]    r6_p [3][3];
    logic signed [W_W-1:0]    r7_w [3];
    logic [WMAG_W-1:0]        r8_mag [3], r9_mag [3], r10_mag [3];
    logic                     r8_neg [3], r9_neg [3], r10_neg [3];
    logic                     r11_neg [3], r12_neg [3], r13_neg [3];
    logic [WMAG_W-1:0]        r9_max;
    logic [WMAG_W-1:0]        w_max01;
    logic [SH_W-1:0]          n_sh;
    logic [SH_W-1:0]          r10_sh;
    logic [WN_W-1:0]          r11_m [3], r12_m [3], r13_m [3];
    logic [2*WN_W-1:0]        r12_sq [3];
    logic [SS_W-1:0]          r13_ss;
    logic [SS_W-1:0]          w_c2_s [WORLD_LN];

    // world chain and output
    logic                     c2_vld;
    logic                     c2_x;
    logic [FRAC_BITS:0]       c2_k   [WORLD_LN];
    logic                     c2_neg [WORLD_LN];
    logic signed [WORLD_W-1:0] w_wd  [WORLD_LN];
    logic                     r_out_vld;
    t_out_word                r_out;

    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld  <= i_in.valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r6_vld  <= c1_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
            r13_vld <= r12_vld;
            r_out_vld <= c2_vld;
        end
    end

    // ---- normal front end: squares, sums, up-axis test, lane setup ----
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_l[0] <= i_in.data.local_x;
            r1_l[1] <= i_in.data.local_y;
            r1_l[2] <= i_in.data.local_z;
            r1_n[0] <= i_in.data.normal_x;
            r1_n[1] <= i_in.data.normal_y;
            r1_n[2] <= i_in.data.normal_z;
            r1_sq[0] <= SQ_W'(PR_W'(i_in.data.normal_x) * PR_W'(i_in.data.normal_x));
            r1_sq[1] <= SQ_W'(PR_W'(i_in.data.normal_y) * PR_W'(i_in.data.normal_y));
            r1_sq[2] <= SQ_W'(PR_W'(i_in.data.normal_z) * PR_W'(i_in.data.normal_z));
            r1_nxy  <= PR_W'(i_in.data.normal_x) * PR_W'(i_in.data.normal_y);
            r1_nyz  <= PR_W'(i_in.data.normal_y) * PR_W'(i_in.data.normal_z);
            r1_nxz  <= PR_W'(i_in.data.normal_x) * PR_W'(i_in.data.normal_z);

            r2_l   <= r1_l;
            r2_n   <= r1_n;
            r2_ny2 <= r1_sq[1];
            r2_nxy <= r1_nxy;
            r2_nyz <= r1_nyz;
            r2_nxz <= r1_nxz;
            r2_l2  <= L2_W'(r1_sq[0]) + L2_W'(r1_sq[1]) + L2_W'(r1_sq[2]);
            r2_h2  <= L2_W'(r1_sq[0]) + L2_W'(r1_sq[2]);
            r2_g2  <= L2_W'(r1_sq[1]) + L2_W'(r1_sq[2]);

            r3_l   <= r2_l;
            r3_n   <= r2_n;
            r3_nxy <= r2_nxy;
            r3_nyz <= r2_nyz;
            r3_nxz <= r2_nxz;
            r3_l2  <= r2_l2;
            r3_h2  <= r2_h2;
            r3_g2  <= r2_g2;
            r3_a   <= UPM_W'(r2_ny2) * UPM_W'(UP_NUM);
            r3_b   <= UPM_W'(r2_l2) * UPM_W'(UP_DEN);

            r4_l   <= r3_l;
            r4_n   <= r3_n;
            r4_nxy <= r3_nxy;
            r4_nyz <= r3_nyz;
            r4_nxz <= r3_nxz;
            r4_l2  <= r3_l2;
            r4_upy <= r3_a < r3_b;
            r4_q2  <= (r3_a < r3_b) ? r3_h2 : r3_g2;
            r4_inv <= r3_l2 == '0;

            r5_l   <= r4_l;
            r5_l2  <= r4_l2;
            r5_q2  <= r4_q2;
            r5_s2  <= SS_W'(r4_l2) * SS_W'(r4_q2);
            r5_upy <= r4_upy;
            r5_inv <= r4_inv;
            for (int l = 0; l < FRAME_LN; l++) begin
                r5_m[l]   <= LANE_MW'(w_c[l][LANE_CW-1] ? -w_c[l] : w_c[l]);
                r5_neg[l] <= w_c[l][LANE_CW-1];
            end
        end
    end

    // lanes: z0..z2, x terms (two), y0..y2
    always_comb begin
        w_q2s = LANE_CW'(r4_q2);
        w_c[0] = LANE_CW'(r4_n[0]);
        w_c[1] = LANE_CW'(r4_n[1]);
        w_c[2] = LANE_CW'(r4_n[2]);
        if (r4_upy) begin
            w_c[3] = LANE_CW'(r4_n[2]);
            w_c[4] = -LANE_CW'(r4_n[0]);
            w_c[5] = -LANE_CW'(r4_nxy);
            w_c[6] = w_q2s;
            w_c[7] = -LANE_CW'(r4_nyz);
        end else begin
            w_c[3] = -LANE_CW'(r4_n[2]);
            w_c[4] = LANE_CW'(r4_n[1]);
            w_c[5] = w_q2s;
            w_c[6] = -LANE_CW'(r4_nxy);
            w_c[7] = -LANE_CW'(r4_nxz);
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_c1_s[l] = SS_W'(r5_l2);
        end
        w_c1_s[3] = SS_W'(r5_q2);
        w_c1_s[4] = SS_W'(r5_q2);
        for (int l = 5; l < FRAME_LN; l++) begin
            w_c1_s[l] = r5_s2;
        end
    end

    assign w_c1_xin = {r5_l[0], r5_l[1], r5_l[2], r5_upy, r5_inv};

    tfw_chain #(
        .LANES (FRAME_LN),
        .MW    (LANE_MW),
        .SW    (LANE_SW),
        .F     (FRAME_BITS),
        .XW    (XW1)
    ) u_frame (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r5_vld),
        .i_x    (w_c1_xin),
        .i_m    (r5_m),
        .i_neg  (r5_neg),
        .i_s    (w_c1_s),
        .o_vld  (c1_vld),
        .o_x    (c1_x),
        .o_k    (c1_k),
        .o_neg  (c1_neg)
    );

    // ---- frame assembly and rotation ----
    always_comb begin
        for (int l = 0; l < FRAME_LN; l++) begin
            w_v[l] = c1_neg[l] ? -AX_W'(c1_k[l]) : AX_W'(c1_k[l]);
        end
        w_c1_l[0] = c1_x[XW1-1 -: DATA_W];
        w_c1_l[1] = c1_x[XW1-1-DATA_W -: DATA_W];
        w_c1_l[2] = c1_x[XW1-1-2*DATA_W -: DATA_W];
        // x basis: the missing component is zero
        w_bas[0][0] = c1_x[1] ? w_v[3] : '0;
        w_bas[0][1] = c1_x[1] ? '0 : w_v[3];
        w_bas[0][2] = w_v[4];
        w_bas[1][0] = w_v[5];
        w_bas[1][1] = w_v[6];
        w_bas[1][2] = w_v[7];
        w_bas[2][0] = w_v[0];
        w_bas[2][1] = w_v[1];
        w_bas[2][2] = w_v[2];
    end

    always_comb begin
        w_max01 = (r8_mag[0] > r8_mag[1]) ? r8_mag[0] : r8_mag[1];
    end

    // block shift: smallest shift that brings the largest magnitude under 2^31
    always_comb begin
        n_sh = '0;
        for (int b = WN_W; b < WMAG_W; b++) begin
            if (r9_max[b]) begin
                n_sh = SH_W'(b - (WN_W - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_inv <= c1_x[0];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r6_p[i][j] <= P_W'(w_c1_l[j]) * P_W'(w_bas[j][i]);
                end
            end

            r7_inv <= r6_inv;
            for (int i = 0; i < 3; i++) begin
                r7_w[i] <= W_W'(r6_p[i][0]) + W_W'(r6_p[i][1]) + W_W'(r6_p[i][2]);
            end

            r8_inv <= r7_inv;
            for (int i = 0; i < 3; i++) begin
                r8_mag[i] <= WMAG_W'(r7_w[i][W_W-1] ? -r7_w[i] : r7_w[i]);
                r8_neg[i] <= r7_w[i][W_W-1];
            end

            r9_mag <= r8_mag;
            r9_neg <= r8_neg;
            r9_max <= (w_max01 > r8_mag[2]) ? w_max01 : r8_mag[2];
            r9_inv <= r8_inv || ((r8_mag[0] == '0) && (r8_mag[1] == '0)
                                 && (r8_mag[2] == '0));

            r10_mag <= r9_mag;
            r10_neg <= r9_neg;
            r10_inv <= r9_inv;
            r10_sh  <= n_sh;

            r11_neg <= r10_neg;
            r11_inv <= r10_inv;
            for (int i = 0; i < 3; i++) begin
                r11_m[i] <= WN_W'(r10_mag[i] >> r10_sh);
            end

            r12_m   <= r11_m;
            r12_neg <= r11_neg;
            r12_inv <= r11_inv;
            for (int i = 0; i < 3; i++) begin
                r12_sq[i] <= (2 * WN_W)'(r11_m[i]) * (2 * WN_W)'(r11_m[i]);
            end

            r13_m   <= r12_m;
            r13_neg <= r12_neg;
            r13_inv <= r12_inv;
            r13_ss  <= SS_W'(r12_sq[0]) + SS_W'(r12_sq[1]) + SS_W'(r12_sq[2]);
        end
    end

    always_comb begin
        for (int l = 0; l < WORLD_LN; l++) begin
            w_c2_s[l] = r13_ss;
        end
    end

    tfw_chain #(
        .LANES (WORLD_LN),
        .MW    (WN_W),
        .SW    (SS_W),
        .F     (FRAC_BITS),
        .XW    (1)
    ) u_world (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (r13_vld),
        .i_x    (r13_inv),
        .i_m    (r13_m),
        .i_neg  (r13_neg),
        .i_s    (w_c2_s),
        .o_vld  (c2_vld),
        .o_x    (c2_x),
        .o_k    (c2_k),
        .o_neg  (c2_neg)
    );

    // ---- output word ----
    always_comb begin
        for (int l = 0; l < WORLD_LN; l++) begin
            w_wd[l] = c2_neg[l] ? -WORLD_W'(c2_k[l]) : WORLD_W'(c2_k[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.world_x <= c2_x ? '0 : w_wd[0];
            r_out.world_y <= c2_x ? '0 : w_wd[1];
            r_out.world_z <= c2_x ? '0 : w_wd[2];
            r_out.invalid <= c2_x;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

@@ tb/tfw_world_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfw_world_checker
// Watches both channels of the tangent-frame to world transform, predicts
// the world direction of every accepted input word with an exact integer
// model, and compares each accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module tfw_world_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tfw_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tfw_pkg::t_out_word i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tfw_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    t_out_word world_q[$];

    // sign(c) * round(|c| * 2^f / sqrt(s)), largest k with (2k-1)^2*s <= 4*c^2*2^2f
    function automatic longint signed unit_scale(input longint signed c,
                                                 input bit [63:0] s, input int f);
        bit [63:0]  m;
        bit [63:0]  k;
        bit [63:0]  t;
        bit [63:0]  a;
        bit [191:0] mm;
        bit [191:0] lhs;
        bit [191:0] rhs;
        m = (c < 0) ? 64'(-c) : 64'(c);
        if (s == 0 || m == 0) return 0;
        mm  = 192'(m);
        rhs = (mm * mm) << (2 + 2 * f);
        k   = 0;
        for (int b = f; b >= 0; b--) begin
            t   = k | (64'd1 << b);
            a   = 2 * t - 1;
            lhs = 192'(a) * 192'(a) * 192'(s);
            if (lhs <= rhs) k = t;
        end
        return (c < 0) ? -longint'(k) : longint'(k);
    endfunction

    function automatic t_out_word world_dir(input t_in_word w);
        longint signed lc[3];
        longint signed n[3];
        longint signed ax[3];
        longint signed ay[3];
        longint signed az[3];
        longint signed wv[3];
        bit [63:0]     l2;
        bit [63:0]     q2;
        bit [63:0]     mag;
        bit [63:0]     wmax;
        bit [63:0]     ss;
        int            sh;
        t_out_word     r;
        lc[0] = w.local_x;  lc[1] = w.local_y;  lc[2] = w.local_z;
        n[0]  = w.normal_x; n[1]  = w.normal_y; n[2]  = w.normal_z;
        r = '0;
        l2 = 64'(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
        if (l2 == 0) begin
            r.invalid = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) az[i] = unit_scale(n[i], l2, FRAME_BITS);
        if (64'd1000000 * 64'(n[1] * n[1]) < 64'd998001 * l2) begin
            q2 = 64'(n[0] * n[0] + n[2] * n[2]);
            ax[0] = unit_scale(n[2], q2, FRAME_BITS);
            ax[1] = 0;
            ax[2] = unit_scale(-n[0], q2, FRAME_BITS);
            ay[0] = unit_scale(-n[0] * n[1], l2 * q2, FRAME_BITS);
            ay[1] = unit_scale(longint'(q2), l2 * q2, FRAME_BITS);
            ay[2] = unit_scale(-n[1] * n[2], l2 * q2, FRAME_BITS);
        end else begin
            q2 = 64'(n[1] * n[1] + n[2] * n[2]);
            ax[0] = 0;
            ax[1] = unit_scale(-n[2], q2, FRAME_BITS);
            ax[2] = unit_scale(n[1], q2, FRAME_BITS);
            ay[0] = unit_scale(longint'(q2), l2 * q2, FRAME_BITS);
            ay[1] = unit_scale(-n[0] * n[1], l2 * q2, FRAME_BITS);
            ay[2] = unit_scale(-n[0] * n[2], l2 * q2, FRAME_BITS);
        end
        wmax = 0;
        for (int i = 0; i < 3; i++) begin
            wv[i] = lc[0] * ax[i] + lc[1] * ay[i] + lc[2] * az[i];
            mag = (wv[i] < 0) ? 64'(-wv[i]) : 64'(wv[i]);
            if (mag > wmax) wmax = mag;
        end
        if (wmax == 0) begin
            r.invalid = 1'b1;
            return r;
        end
        sh = 0;
        while ((wmax >> sh) >= (64'd1 << 31)) sh++;
        ss = 0;
        for (int i = 0; i < 3; i++) begin
            mag = ((wv[i] < 0) ? 64'(-wv[i]) : 64'(wv[i])) >> sh;
            wv[i] = (wv[i] < 0) ? -longint'(mag) : longint'(mag);
            ss += mag * mag;
        end
        r.world_x = 16'(unit_scale(wv[0], ss, FB));
        r.world_y = 16'(unit_scale(wv[1], ss, FB));
        r.world_z = 16'(unit_scale(wv[2], ss, FB));
        r.invalid = 1'b0;
        return r;
    endfunction

    assign o_pending = world_q.size();

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            world_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready) world_q.push_back(world_dir(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (world_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output word %h", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = world_q.pop_front();
                    if (want.world_x !== i_out_data.world_x
                            || want.world_y !== i_out_data.world_y
                            || want.world_z !== i_out_data.world_z
                            || want.invalid !== i_out_data.invalid) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: expected x=%0d y=%0d z=%0d inv=%0b,",
                                      " got x=%0d y=%0d z=%0d inv=%0b"},
                                     want.world_x, want.world_y, want.world_z,
                                     want.invalid,
                                     i_out_data.world_x, i_out_data.world_y,
                                     i_out_data.world_z, i_out_data.invalid);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random local/normal words into the tangent-frame to
// world transform with random source gaps and sink stalls; the checker
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import tfw_pkg::*;

    localparam int N_RANDOM = 830;
    localparam int LIMIT    = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   no_idle = 1'b0;
    int   stall_cnt = 0;

    tfw_if #(.T(t_in_word))  in_ch ();
    tfw_if #(.T(t_out_word)) out_ch ();

    tangent_frame_local_to_world i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    tfw_world_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout");
            $display("** tangent_frame_local_to_world: FAILED **");
            $finish;
        end
    end

    // sink: after each accepted word, hold ready low for a random stall (none under no_idle)
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_cnt    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            n = no_idle ? 0 : $urandom_range(0, 3);
            stall_cnt    <= n;
            out_ch.ready <= (n == 0);
        end else if (stall_cnt > 0) begin
            stall_cnt    <= stall_cnt - 1;
            out_ch.ready <= (stall_cnt == 1);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send(input logic [15:0] lx, ly, lz, nx, ny, nz);
        int   gap;
        t_in_word w;
        w = '{lx, ly, lz, nx, ny, nz};
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [15:0] small_val(input int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    initial begin
        int kind;
        logic [15:0] lx, ly, lz, nx, ny, nz;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero normal, zero local, normal on each axis, near-y threshold, extremes
        send(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0002, 16'h0003);
        send(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0005, 16'h0000);
        send(16'h4000, 16'h4000, 16'h4000, 16'h0000, 16'h8000, 16'h0000);
        send(16'h1000, 16'h2000, 16'h3000, 16'h0000, 16'h7fff, 16'h0000);
        send(16'h4000, 16'h0000, 16'h0000, 16'h0007, 16'h0000, 16'h0000);
        send(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(16'h8000, 16'h7fff, 16'h0001, 16'h8000, 16'h7fff, 16'hffff);
        send(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send(16'h2000, 16'hc000, 16'h4000, 16'd22, 16'd500, 16'd0);
        send(16'h2000, 16'hc000, 16'h4000, 16'd23, 16'd500, 16'd0);
        send(16'h2000, 16'hc000, 16'h4000, 16'd0, 16'hfe0c, 16'd22);
        send(16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h0000, 16'h8000);
        send(16'h8000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            lx = 16'($urandom); ly = 16'($urandom); lz = 16'($urandom);
            nx = 16'($urandom); ny = 16'($urandom); nz = 16'($urandom);
            case (kind)
                0: begin
                    nx = small_val(3); ny = small_val(3); nz = small_val(3);
                end
                1: begin
                    ny = 16'($urandom_range(500, 32767));
                    if ($urandom_range(0, 1)) ny = -ny;
                    nx = small_val(40); nz = small_val(40);
                end
                2: begin
                    nx = small_val(1); nz = small_val(1);
                end
                3: begin
                    lx = small_val(2); ly = small_val(2); lz = small_val(2);
                end
                4: begin
                    lx = '0; ly = '0; lz = '0;
                end
                default: ;
            endcase
            send(lx, ly, lz, nx, ny, nz);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("** tangent_frame_local_to_world: PASSED **");
        else
            $display("** tangent_frame_local_to_world: FAILED **");
        $finish;
    end

endmodule
